>>> hw/rtl/b2r_pkg.sv
package b2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int DIGITS   = 4;
    localparam int SYM_W    = 3;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [3:0]         digit_t;
    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [1:0]         place_t;

    // largest value that still has a numeral
    localparam value_t TOP_VALUE = value_t'(3999);
    // symbol code of the letter I, also the filler on an empty result
    localparam sym_t   SYM_I     = sym_t'(0);
    // symbol code of the letter M, the highest code in use
    localparam sym_t   SYM_M     = sym_t'(6);

    // decimal digits handed from the converter to the emitter
    typedef struct packed {
        logic                  vld;
        logic [DIGITS-1:0][3:0] dig;
    } bcd_t;

    typedef enum logic {
        DB_IDLE,
        DB_SHIFT
    } db_state_t;

    typedef enum logic {
        EM_IDLE,
        EM_RUN
    } em_state_t;

    // number of symbols one decimal digit turns into
    function automatic logic [2:0] dig_len(digit_t d);
        logic [2:0] r;
        case (d)
            4'd0:    r = 3'd0;
            4'd1:    r = 3'd1;
            4'd2:    r = 3'd2;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd2;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd2;
            4'd7:    r = 3'd3;
            4'd8:    r = 3'd4;
            4'd9:    r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // symbol number k of a digit at a decimal place
    function automatic sym_t dig_sym(digit_t d, place_t place, logic [2:0] k);
        sym_t one;
        sym_t five;
        sym_t ten;
        sym_t r;
        one  = {place, 1'b0};
        five = one + sym_t'(1);
        ten  = one + sym_t'(2);
        if (d == 4'd9)
        begin
            r = (k == 3'd0) ? one : ten;
        end
        else if (d >= 4'd5)
        begin
            r = (k == 3'd0) ? five : one;
        end
        else if (d == 4'd4)
        begin
            r = (k == 3'd0) ? one : five;
        end
        else
        begin
            r = one;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/b2r_dabble.sv
module b2r_dabble (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  b2r_pkg::value_t value,
    output b2r_pkg::bcd_t   bcd,
    output logic            busy
);
    import b2r_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    db_state_t               state_reg, state_next;
    value_t                  sh_reg, sh_next;
    logic [DIGITS*4-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [DIGITS*4-1:0]     adj;
    logic                    last_bit;

    assign last_bit = (cnt_reg == CNT_W'(VALUE_W - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DB_IDLE:
            begin
                if (load)
                begin
                    state_next = DB_SHIFT;
                end
            end
            DB_SHIFT:
            begin
                if (last_bit)
                begin
                    state_next = DB_IDLE;
                end
            end
            default: state_next = DB_IDLE;
        endcase
    end

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // datapath, one value bit per cycle
    always_comb
    begin
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            DB_IDLE:
            begin
                if (load)
                begin
                    sh_next  = value;
                    bcd_next = '0;
                    cnt_next = '0;
                end
            end
            DB_SHIFT:
            begin
                bcd_next  = {adj[DIGITS*4-2:0], sh_reg[VALUE_W-1]};
                sh_next   = {sh_reg[VALUE_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
                done_next = last_bit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DB_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign bcd.vld = done_reg;
    assign bcd.dig = bcd_reg;
    assign busy    = (state_reg == DB_SHIFT) || done_reg;

    // digits come out only right after the last shift
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == DB_SHIFT))
        else $error("bcd result without a finished shift run");

endmodule

>>> hw/rtl/b2r_emit.sv
module b2r_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  b2r_pkg::bcd_t bcd,
    output logic          vld,
    output b2r_pkg::sym_t sym,
    output logic          last,
    output logic          busy
);
    import b2r_pkg::*;

    em_state_t              state_reg, state_next;
    logic [DIGITS-1:0][3:0] dig_reg, dig_next;
    place_t                 pos_reg, pos_next;
    logic [2:0]             k_reg, k_next;
    logic                   vld_reg, vld_next;
    sym_t                   sym_reg, sym_next;
    logic                   last_reg, last_next;

    digit_t                 cur;
    logic [2:0]             cur_len;
    logic                   end_dig;
    logic [2:0]             lower;
    logic [2:0]             first;

    // highest nonzero digit below a limit, flag in the top bit
    function automatic logic [2:0] find_nz(logic [DIGITS-1:0][3:0] d, logic [2:0] lim);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if ((3'(i) < lim) && (d[i] != 4'd0))
            begin
                r = {1'b1, 2'(i)};
            end
        end
        return r;
    endfunction

    assign cur     = dig_reg[pos_reg];
    assign cur_len = dig_len(cur);
    assign end_dig = (k_reg == cur_len - 3'd1);
    assign lower   = find_nz(dig_reg, {1'b0, pos_reg});
    assign first   = find_nz(bcd.dig, 3'(DIGITS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EM_IDLE:
            begin
                if (bcd.vld)
                begin
                    state_next = EM_RUN;
                end
            end
            EM_RUN:
            begin
                if (end_dig && !lower[2])
                begin
                    state_next = EM_IDLE;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    // one symbol per cycle, walking digits from the top
    always_comb
    begin
        dig_next  = dig_reg;
        pos_next  = pos_reg;
        k_next    = k_reg;
        vld_next  = 1'b0;
        sym_next  = sym_reg;
        last_next = last_reg;
        case (state_reg)
            EM_IDLE:
            begin
                if (bcd.vld)
                begin
                    dig_next = bcd.dig;
                    pos_next = first[1:0];
                    k_next   = 3'd0;
                end
            end
            EM_RUN:
            begin
                vld_next  = 1'b1;
                sym_next  = dig_sym(cur, pos_reg, k_reg);
                last_next = end_dig && !lower[2];
                if (end_dig)
                begin
                    pos_next = lower[1:0];
                    k_next   = 3'd0;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        pos_reg  <= pos_next;
        k_reg    <= k_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
    end

    assign vld  = vld_reg;
    assign sym  = sym_reg;
    assign last = last_reg;
    assign busy = (state_reg == EM_RUN);

    // the closing beat of a run leaves the emitter idle
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && last_reg |-> state_reg == EM_IDLE)
        else $error("emitter still running after last beat");

    // new digits only arrive while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        bcd.vld |-> state_reg == EM_IDLE)
        else $error("digits delivered to a running emitter");

    // no letter above M
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> sym_reg <= SYM_M)
        else $error("symbol code out of range");

endmodule

>>> hw/rtl/binary_to_roman_numeral.sv
// Binary to Roman numeral converter.
// Command channel: drive value and pulse start; a beat is taken at a rising
// edge with start high and busy low. Results come out one beat per cycle on
// symbol/last/empty_res/out_of_range, marked by strobe for a single cycle;
// the receiver cannot hold them off. last marks the final beat of a run.
// Values 1..3999: the value is turned into four decimal digits one bit per
// cycle, the digits are handed over to the emitter, and the emitter
// produces one symbol per cycle, the n symbols of a numeral back to back;
// busy stays high until the last symbol is registered. The longest numeral,
// for 3888, has fifteen symbols.
// Zero and values above 3999 give a single empty beat on the cycle after
// acceptance and do not raise busy, so such items can be taken every cycle
// while busy is low. Reset clears the state registers and valid flags;
// no beat is pending after reset.
module binary_to_roman_numeral (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  b2r_pkg::value_t value,
    output logic            strobe,
    output b2r_pkg::sym_t   symbol,
    output logic            last,
    output logic            empty_res,
    output logic            out_of_range
);
    import b2r_pkg::*;

    logic   accept;
    logic   special;
    logic   spec_vld_reg;
    logic   spec_oor_reg;
    bcd_t   bcd;
    logic   db_busy;
    logic   em_vld;
    sym_t   em_sym;
    logic   em_last;
    logic   em_busy;

    assign accept  = start && !busy;
    assign special = (value == '0) || (value > TOP_VALUE);

    // empty result for zero and out of range values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_vld_reg <= 1'b0;
        end
        else
        begin
            spec_vld_reg <= accept && special;
        end
    end

    always_ff @(posedge clk)
    begin
        spec_oor_reg <= (value > TOP_VALUE);
    end

    b2r_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept && !special),
        .value (value),
        .bcd   (bcd),
        .busy  (db_busy)
    );

    b2r_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .bcd   (bcd),
        .vld   (em_vld),
        .sym   (em_sym),
        .last  (em_last),
        .busy  (em_busy)
    );

    assign busy         = db_busy || em_busy;
    assign strobe       = spec_vld_reg || em_vld;
    assign symbol       = spec_vld_reg ? SYM_I : em_sym;
    assign last         = spec_vld_reg ? 1'b1 : em_last;
    assign empty_res    = spec_vld_reg;
    assign out_of_range = spec_vld_reg && spec_oor_reg;

    // the two result sources never collide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(spec_vld_reg && em_vld))
        else $error("empty beat and symbol beat in the same cycle");

    // an empty beat follows a taken command
    assert property (@(posedge clk) disable iff (!rst_n)
        spec_vld_reg |-> $past(accept))
        else $error("empty beat without a command");

endmodule
